// File: hdl/mctx_pkg.sv
package mctx_pkg;

  localparam int MatDim    = 4;
  localparam int NumPairs  = 8;
  localparam int NumElems  = MatDim * MatDim;
  localparam int ElemW     = 32;
  localparam int PairW     = 2 * ElemW;
  localparam int FracBits  = 16;
  localparam int ProdW     = 2 * ElemW;
  localparam int PairSumW  = ProdW + 1;
  localparam int TotalW    = ProdW + 2;
  localparam int ShiftW    = TotalW - FracBits;
  localparam int CfgIndexW = 8;
  localparam int PairIdxW  = $clog2(NumPairs);

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic [PairW-1:0]        pair_t;
  typedef elem_t                   vec_t [MatDim];

  // The identity matrix, packed as element pairs in column-major order.
  localparam pair_t MatReset [NumPairs] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [ElemW-1:0] col_elem_0;
    logic signed [ElemW-1:0] col_elem_1;
    logic signed [ElemW-1:0] col_elem_2;
    logic signed [ElemW-1:0] col_elem_3;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemW-1:0] res_elem_0;
    logic signed [ElemW-1:0] res_elem_1;
    logic signed [ElemW-1:0] res_elem_2;
    logic signed [ElemW-1:0] res_elem_3;
  } out_item_t;

endpackage

// File: hdl/matrix_column_transform_4x4.sv
// Multiplies a 4x4 signed Q16.16 matrix, held in eight 64-bit registers in
// column-major order, by one column per transfer. A column is taken at
// every clock edge where start is high; busy is always low, so a column may
// be presented in every cycle and the block sustains one column per cycle.
// The matching product column appears on result, with done high for exactly
// one cycle, once the column has passed the input register, the
// multipliers, two adder levels and the shift/saturate register.
// The receiver cannot stall the output, so it must take every result in the
// cycle it is shown. Each row sum is exact; it is shifted right by sixteen
// (rounding towards minus infinity) and saturated to 32 bits. The matrix is
// the identity after reset. Register writes are always accepted, writes to
// an index beyond seven are ignored, and the matrix should only be changed
// while no column is in flight.
module matrix_column_transform_4x4 import mctx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             col,
  output logic                 done,
  output out_item_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [PairW-1:0]     cfg_data
);

  // One valid bit for each register stage, the input register included.
  localparam int Latency = 5;

  pair_t               mat_pair [NumPairs];
  elem_t               mat_elem [NumElems];
  vec_t                mat_row  [MatDim];
  vec_t                col_q;
  elem_t               row_res  [MatDim];
  logic [Latency-1:0]  valid;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Matrix registers. An index outside the register list leaves them alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumPairs; i++) begin
        mat_pair[i] <= MatReset[i];
      end
    end else if (cfg_valid && cfg_ready && cfg_index < CfgIndexW'(NumPairs)) begin
      mat_pair[cfg_index[PairIdxW-1:0]] <= cfg_data;
    end
  end

  // Element k sits at row k mod 4, column k / 4; even elements occupy the
  // low half of their pair.
  always_comb begin
    for (int k = 0; k < NumElems; k++) begin
      mat_elem[k] = (k % 2 == 1) ? mat_pair[k / 2][PairW-1:ElemW]
                                 : mat_pair[k / 2][ElemW-1:0];
    end
    for (int r = 0; r < MatDim; r++) begin
      for (int e = 0; e < MatDim; e++) begin
        mat_row[r][e] = mat_elem[r + MatDim * e];
      end
    end
  end

  // Input register. The data path runs freely; only the valid bits, which
  // travel alongside the data, need a reset.
  always_ff @(posedge clk) begin
    col_q[0] <= col.col_elem_0;
    col_q[1] <= col.col_elem_1;
    col_q[2] <= col.col_elem_2;
    col_q[3] <= col.col_elem_3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Latency-2:0], start && !busy};
    end
  end

  for (genvar r = 0; r < MatDim; r++) begin : g_row
    mctx_row u_row (
      .clk     (clk),
      .mat_row (mat_row[r]),
      .col     (col_q),
      .res     (row_res[r])
    );
  end

  assign done              = valid[Latency-1];
  assign result.res_elem_0 = row_res[0];
  assign result.res_elem_1 = row_res[1];
  assign result.res_elem_2 = row_res[2];
  assign result.res_elem_3 = row_res[3];

endmodule

// File: hdl/mctx_row.sv
// One row of the product: four multiplies, a two-level adder tree, then
// the fractional shift and saturation, each behind its own register.
module mctx_row import mctx_pkg::*; (
  input  logic  clk,
  input  vec_t  mat_row,
  input  vec_t  col,
  output elem_t res
);

  logic signed [ProdW-1:0]    prod [MatDim];
  logic signed [PairSumW-1:0] pair_sum [2];
  logic signed [TotalW-1:0]   total;
  logic signed [ShiftW-1:0]   shifted;
  elem_t                      res_next;

  always_ff @(posedge clk) begin
    for (int e = 0; e < MatDim; e++) begin
      prod[e] <= mat_row[e] * col[e];
    end
    pair_sum[0] <= PairSumW'(prod[0]) + PairSumW'(prod[1]);
    pair_sum[1] <= PairSumW'(prod[2]) + PairSumW'(prod[3]);
    total       <= TotalW'(pair_sum[0]) + TotalW'(pair_sum[1]);
    res         <= res_next;
  end

  // Dropping the fraction bits of a two's complement value rounds
  // towards minus infinity.
  assign shifted = total[TotalW-1:FracBits];

  always_comb begin
    if (shifted[ShiftW-1:ElemW-1] == '0 || shifted[ShiftW-1:ElemW-1] == '1) begin
      res_next = shifted[ElemW-1:0];
    end else if (shifted[ShiftW-1]) begin
      res_next = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      res_next = {1'b0, {(ElemW-1){1'b1}}};
    end
  end

endmodule

// File: bench/column_product_checker.sv
module column_product_checker import mctx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             col,
  input  logic                 done,
  input  out_item_t            result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [PairW-1:0]     cfg_data,
  output int                   pending,
  output int                   fails
);

  // Wide enough for the exact sum of four full 64-bit products.
  typedef logic signed [ProdW+3:0] acc_t;

  localparam elem_t ElemMax    = 32'sh7FFF_FFFF;
  localparam elem_t ElemMin    = 32'sh8000_0000;
  localparam int    MaxReports = 40;

  pair_t     mat_pairs [NumPairs];
  out_item_t product_q [$];
  int        reported;

  function automatic elem_t mat_entry(int row, int idx);
    int k;
    k = row + idx * MatDim;
    return (k % 2) ? mat_pairs[k / 2][PairW-1:ElemW] : mat_pairs[k / 2][ElemW-1:0];
  endfunction

  function automatic out_item_t column_product(in_item_t c);
    elem_t vin  [MatDim];
    elem_t vout [MatDim];
    acc_t  sum, lhs, rhs, hi_lim, lo_lim;
    vin    = '{c.col_elem_0, c.col_elem_1, c.col_elem_2, c.col_elem_3};
    hi_lim = ElemMax;
    lo_lim = ElemMin;
    for (int r = 0; r < MatDim; r++) begin
      sum = '0;
      for (int e = 0; e < MatDim; e++) begin
        lhs = mat_entry(r, e);
        rhs = vin[e];
        sum = sum + lhs * rhs;
      end
      // Arithmetic shift of the exact sum floors towards minus infinity.
      sum = sum >>> FracBits;
      if (sum > hi_lim) begin
        vout[r] = ElemMax;
      end else if (sum < lo_lim) begin
        vout[r] = ElemMin;
      end else begin
        vout[r] = sum[ElemW-1:0];
      end
    end
    return {vout[0], vout[1], vout[2], vout[3]};
  endfunction

  task automatic flag_error(input string msg);
    fails++;
    if (reported < MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    reported++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    elem_t     got_v  [MatDim];
    elem_t     want_v [MatDim];
    if (rst) begin
      mat_pairs = MatReset;
      product_q.delete();
      pending  <= 0;
      fails    = 0;
      reported = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NumPairs) begin
        mat_pairs[cfg_index[PairIdxW-1:0]] = cfg_data;
      end
      if (done) begin
        if (product_q.size() == 0) begin
          flag_error($sformatf("product column %h with no column outstanding", result));
        end else begin
          want   = product_q.pop_front();
          got_v  = '{result.res_elem_0, result.res_elem_1,
                     result.res_elem_2, result.res_elem_3};
          want_v = '{want.res_elem_0, want.res_elem_1, want.res_elem_2, want.res_elem_3};
          for (int r = 0; r < MatDim; r++) begin
            if (got_v[r] !== want_v[r]) begin
              flag_error($sformatf("res_elem_%0d got %0d, expected %0d",
                                   r, got_v[r], want_v[r]));
            end
          end
        end
      end
      if (start && !busy) begin
        product_q.push_back(column_product(col));
      end
      pending <= product_q.size();
    end
  end

endmodule

// File: bench/matrix_column_transform_4x4_tb.sv
module matrix_column_transform_4x4_tb;
  import mctx_pkg::*;

  // The block takes one column per cycle and shows each product column on
  // its done strobe. The random part runs in phases, each with its own matrix.
  localparam int PhaseCount    = 10;
  localparam int PhaseItems    = 70;
  localparam int LatencyCycles = 4;

  // Ways of filling the matrix before a phase.
  typedef enum {FillUniform, FillIdentity, FillRandom, FillExtreme, FillWide} fill_e;

  // Every input of the block is at a known value from time zero.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  in_item_t             col       = '0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [PairW-1:0]     cfg_data  = '0;

  logic      busy;
  logic      done;
  logic      cfg_ready;
  out_item_t result;
  int        pending;
  int        fails;

  // When clear, the sender presents columns and register writes back to back.
  bit gaps_on;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_column_transform_4x4 u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .col       (col),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker watches both channels, keeps its own copy of the matrix and
  // compares every product column against its own arithmetic.
  column_product_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .col       (col),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fails     (fails)
  );

  // A mix of the range extremes, small values between minus and plus four,
  // tiny raw values that make the floor of negative sums visible, and
  // fully random words.
  function automatic elem_t pick_elem();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 8 << FracBits) - (4 << FracBits);
      3:       return $urandom_range(0, 3) - 2;
      default: return $urandom();
    endcase
  endfunction

  // Presents one column and returns at the edge where its transfer happens.
  // Start is only lowered when a gap is drawn, so a column that follows
  // directly keeps start high without a second assignment in the same step.
  task automatic send_column(input in_item_t c);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    col   <= c;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every product column in flight has been
  // seen. The first edge lets the checker count the last transfer.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register write; valid stays high into the next write unless a gap
  // is drawn, in the same way as start on the column channel.
  task automatic write_pair(input logic [CfgIndexW-1:0] idx, input pair_t val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites all eight pairs while the block is idle. Now and then a write
  // to an index beyond the last pair is slipped in; the block must ignore it.
  task automatic load_matrix(input fill_e how, input pair_t uniform_val);
    pair_t v;
    drain();
    for (int i = 0; i < NumPairs; i++) begin
      case (how)
        FillUniform:  v = uniform_val;
        FillIdentity: v = MatReset[i];
        FillRandom:   v = {pick_elem(), pick_elem()};
        FillExtreme:  v = {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000,
                           $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
        default:      v = {$urandom(), $urandom()};
      endcase
      write_pair(CfgIndexW'(i), v);
      if ($urandom_range(0, 7) == 0) begin
        write_pair(CfgIndexW'($urandom_range(NumPairs, 2 ** CfgIndexW - 1)),
                   {$urandom(), $urandom()});
      end
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst     <= 1'b0;
    gaps_on = 1'b0;

    // The matrix is the identity after reset, so these columns come back
    // unchanged, extremes included.
    send_column({32'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_column({4{32'h7FFF_FFFF}});
    send_column({4{32'h8000_0000}});
    send_column({32'sd65536, -32'sd65536, 32'sd1, -32'sd1});

    // Every element at the positive limit: sums far beyond the range in
    // both directions, so both saturation limits are hit.
    load_matrix(FillUniform, {2{32'h7FFF_FFFF}});
    send_column({4{32'h7FFF_FFFF}});
    send_column({4{32'h8000_0000}});

    // Every element at the negative limit: four products of two to the
    // sixty-second need the full width of the exact sum.
    load_matrix(FillUniform, {2{32'h8000_0000}});
    send_column({4{32'h8000_0000}});
    send_column({4{32'h7FFF_FFFF}});
    send_column({32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 32'sd1});

    // Every element is the smallest step, so the sums are tiny and the
    // shift must floor negative values rather than cut towards zero.
    load_matrix(FillUniform, {2{32'h0000_0001}});
    send_column({-32'sd1, 32'sd0, 32'sd0, 32'sd0});
    send_column({32'sd1, 32'sd1, 32'sd1, 32'sd1});
    send_column({-32'sd65537, 32'sd0, 32'sd0, 32'sd0});
    send_column({32'sd65535, 32'sd1, 32'sd0, 32'sd0});
    send_column({4{-32'sd1}});

    // Writes to indexes past the last pair must leave the matrix alone.
    drain();
    write_pair(CfgIndexW'(NumPairs), {2{32'h7FFF_FFFF}});
    write_pair(CfgIndexW'(2 ** CfgIndexW - 1), '1);
    cfg_valid <= 1'b0;
    send_column({32'sd65536, 32'sd131072, -32'sd65536, 32'sd1});

    // Random phases. Every third phase runs without gaps so that the block
    // sees columns at its full rate; the others scatter idle cycles over
    // the pipeline. An occasional pause mid-phase empties the pipeline.
    for (int p = 0; p < PhaseCount; p++) begin
      gaps_on = (p % 3 != 2);
      case (p % 4)
        0:       load_matrix(FillRandom, '0);
        1:       load_matrix(FillExtreme, '0);
        2:       load_matrix(FillWide, '0);
        default: load_matrix(FillIdentity, '0);
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        send_column({pick_elem(), pick_elem(), pick_elem(), pick_elem()});
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
      end
    end

    // Wait for the last product column, then a little longer so that a
    // stray strobe would still be caught.
    drain();
    repeat (2 * LatencyCycles) @(posedge clk);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A stuck handshake or a missing product column ends the run here.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/mctx_pkg.sv
hdl/mctx_row.sv
hdl/matrix_column_transform_4x4.sv
bench/column_product_checker.sv
bench/matrix_column_transform_4x4_tb.sv
